// File: rtl/rthsv_pkg.sv
// ============================================================================
// rthsv_pkg
// Shared types and constants of the RGB to HSV converter.
// ============================================================================
`default_nettype none

package rthsv_pkg;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned QUO_W   = 12;
  localparam int unsigned NUM_H_W = CH_W + QUO_W;
  localparam int unsigned NUM_S_W = 2 * CH_W;
  localparam int unsigned HUE_W   = 15;
  localparam int unsigned LATENCY = QUO_W + 2;

  localparam logic [HUE_W-1:0] HUE_GREEN = 15'd7680;
  localparam logic [HUE_W-1:0] HUE_BLUE  = 15'd15360;
  localparam logic [HUE_W-1:0] HUE_FULL  = 15'd23040;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    sector_t           sector;
    logic              neg;
    logic              grey;
    logic [CH_W-1:0]   bright;
    logic [CH_W-1:0]   delta;
    logic [CH_W-1:0]   rem_h;
    logic [QUO_W-1:0]  acc_h;
    logic [CH_W-1:0]   rem_s;
    logic [QUO_W-1:0]  acc_s;
  } div_beat_t;

  function automatic logic [HUE_W-1:0] sector_offset(input sector_t sec);
    logic [HUE_W-1:0] off;
    case (sec)
      SEC_GREEN: off = HUE_GREEN;
      SEC_BLUE:  off = HUE_BLUE;
      default:   off = '0;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

// File: rtl/rthsv_prep.sv
// ============================================================================
// rthsv_prep
// Finds max, min and sector of a pixel and forms both dividends.
// ============================================================================
`default_nettype none

module rthsv_prep import rthsv_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [CH_W-1:0] in_red,
  input  wire logic [CH_W-1:0] in_green,
  input  wire logic [CH_W-1:0] in_blue,
  output logic                 out_valid,
  output div_beat_t            out_beat
);

  logic [CH_W-1:0]    mx, mn, delta, a, b, mag;
  logic               neg;
  sector_t            sector;
  logic [NUM_H_W-1:0] num_h;
  logic [NUM_S_W-1:0] num_s;
  logic               valid_r;
  div_beat_t          beat_r, beat_nxt;

  always_comb begin
    mx = (in_red > in_green) ? in_red : in_green;
    mx = (mx > in_blue) ? mx : in_blue;
    mn = (in_red < in_green) ? in_red : in_green;
    mn = (mn < in_blue) ? mn : in_blue;
    delta = mx - mn;
    if (in_red >= mx) begin
      sector = SEC_RED;
      a = in_green;
      b = in_blue;
    end else if (in_green >= mx) begin
      sector = SEC_GREEN;
      a = in_blue;
      b = in_red;
    end else begin
      sector = SEC_BLUE;
      a = in_red;
      b = in_green;
    end
    neg = (a < b);
    mag = neg ? (b - a) : (a - b);
    // A negative difference is divided with rounding up, so delta - 1 is added.
    num_h = ({mag, 12'd0} - {4'd0, mag, 8'd0})
          + (neg ? {{QUO_W{1'b0}}, delta - 8'd1} : '0);
    num_s = {delta, 8'd0} - {8'd0, delta};

    beat_nxt.sector = sector;
    beat_nxt.neg    = neg;
    beat_nxt.grey   = (delta == '0);
    beat_nxt.bright = mx;
    beat_nxt.delta  = delta;
    beat_nxt.rem_h  = num_h[NUM_H_W-1:QUO_W];
    beat_nxt.acc_h  = num_h[QUO_W-1:0];
    beat_nxt.rem_s  = {{(NUM_H_W-NUM_S_W){1'b0}}, num_s[NUM_S_W-1:QUO_W]};
    beat_nxt.acc_s  = num_s[QUO_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

  assign out_valid = valid_r;
  assign out_beat  = beat_r;

endmodule

`default_nettype wire

// File: rtl/rthsv_div_cell.sv
// ============================================================================
// rthsv_div_cell
// One restoring division step for both the hue and the saturation quotient.
// ============================================================================
`default_nettype none

module rthsv_div_cell import rthsv_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  div_beat_t      in_beat,
  output logic           out_valid,
  output div_beat_t      out_beat
);

  logic [CH_W:0] t_h, t_s, d_h, d_s;
  logic          ge_h, ge_s;
  logic [CH_W:0] diff_h, diff_s;
  logic          valid_r;
  div_beat_t     beat_r, beat_nxt;

  always_comb begin
    t_h    = {in_beat.rem_h, in_beat.acc_h[QUO_W-1]};
    t_s    = {in_beat.rem_s, in_beat.acc_s[QUO_W-1]};
    d_h    = {1'b0, in_beat.delta};
    d_s    = {1'b0, in_beat.bright};
    ge_h   = (t_h >= d_h);
    ge_s   = (t_s >= d_s);
    diff_h = t_h - d_h;
    diff_s = t_s - d_s;

    beat_nxt       = in_beat;
    beat_nxt.rem_h = ge_h ? diff_h[CH_W-1:0] : t_h[CH_W-1:0];
    beat_nxt.acc_h = {in_beat.acc_h[QUO_W-2:0], ge_h};
    beat_nxt.rem_s = ge_s ? diff_s[CH_W-1:0] : t_s[CH_W-1:0];
    beat_nxt.acc_s = {in_beat.acc_s[QUO_W-2:0], ge_s};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

  assign out_valid = valid_r;
  assign out_beat  = beat_r;

endmodule

`default_nettype wire

// File: rtl/rgb_to_hsv_converter_unit.sv
// ============================================================================
// rgb_to_hsv_converter_unit
// Converts one 8-bit RGB pixel per clock into hue, saturation and brightness.
// ============================================================================
// A pixel beat is taken at a rising edge where start is high and busy is low.
// busy is high only while reset is applied, so a new pixel may follow in every
// cycle. The pixel's result is on out_hue, out_saturation and out_brightness
// for exactly one cycle, marked by out_valid, once it has passed the front
// stage, the division cells and the output register. Throughput is one
// pixel per clock.
// The pipeline is made of one front stage that finds the maximum channel and
// forms the dividends, a row of twelve division cells that each produce one
// quotient bit of both divisions, and one output register that applies the
// hue sector offset and wraparound.
// Hue is in units of 1/64 degree, 0 to 23039. Grey pixels give zero hue and
// saturation. Synchronous reset empties the pipeline; no result follows from
// pixels in flight at reset. The receiver cannot stall the output.
// ============================================================================
`default_nettype none

module rgb_to_hsv_converter_unit import rthsv_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [CH_W-1:0]  in_red,
  input  wire logic [CH_W-1:0]  in_green,
  input  wire logic [CH_W-1:0]  in_blue,
  output logic                  out_valid,
  output logic [HUE_W-1:0]      out_hue,
  output logic [CH_W-1:0]       out_saturation,
  output logic [CH_W-1:0]       out_brightness
);

  logic              vld [0:QUO_W];
  div_beat_t         beat [0:QUO_W];
  div_beat_t         last;
  logic [HUE_W-1:0]  offset, quo, hue_nxt;
  logic [HUE_W:0]    wrap;
  logic              valid_r;
  logic [HUE_W-1:0]  hue_r;
  logic [CH_W-1:0]   sat_r, bright_r;
  logic [CH_W-1:0]   sat_nxt;

  assign busy = !rst_n;

  rthsv_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .out_valid (vld[0]),
    .out_beat  (beat[0])
  );

  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    rthsv_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld[i]),
      .in_beat   (beat[i]),
      .out_valid (vld[i+1]),
      .out_beat  (beat[i+1])
    );
  end

  always_comb begin
    last   = beat[QUO_W];
    offset = sector_offset(last.sector);
    quo    = {{(HUE_W-QUO_W){1'b0}}, last.acc_h};
    wrap   = {1'b0, offset} + {1'b0, HUE_FULL} - {1'b0, quo};
    if (last.grey) begin
      hue_nxt = '0;
    end else if (!last.neg) begin
      hue_nxt = offset + quo;
    end else if (quo > offset) begin
      hue_nxt = wrap[HUE_W-1:0];
    end else begin
      hue_nxt = offset - quo;
    end
    sat_nxt = last.grey ? '0 : last.acc_s[CH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= vld[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    hue_r    <= hue_nxt;
    sat_r    <= sat_nxt;
    bright_r <= last.bright;
  end

  assign out_valid      = valid_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_brightness = bright_r;

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hue < HUE_FULL)
    else $error("hue out of range");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("result missing after pixel beat");

  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturation == '0) |-> out_hue == '0)
    else $error("grey pixel with nonzero hue");

  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

`default_nettype wire
